>>> hw/rtl/mesh_face_vertex_normals_assert.svh
// Assertion macros shared by the mesh face vertex normals RTL.
`ifndef MESH_FACE_VERTEX_NORMALS_ASSERT_SVH
`define MESH_FACE_VERTEX_NORMALS_ASSERT_SVH
// Same-cycle implication, disabled in reset.
`define MFVN_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mfvn: same-cycle check failed");
// Next-cycle implication, disabled in reset.
`define MFVN_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mfvn: next-cycle check failed");
`endif

>>> hw/rtl/mfvn_pkg.sv
// Package: constants, codes and handshake types of the mesh face vertex normals block.
package mfvn_pkg;

  localparam int VERTEX_COUNT = 1024;
  localparam int VIDX_W       = 10;
  localparam int POS_W        = 20;
  localparam int PWORD_W      = 3 * POS_W;
  localparam int D_W          = 22;   // edge vector component
  localparam int MUL_W        = 23;   // shared multiplier operand
  localparam int PROD_W       = 2 * MUL_W;
  localparam int CROSS_W      = 45;   // cross product component, signed
  localparam int CMAG_W       = 43;   // its magnitude
  localparam int SUMSQ_W      = 88;
  localparam int ROOT_W       = 44;
  localparam int LEN_W        = 43;
  localparam int ACC_W        = 56;
  localparam int ACCWORD_W    = 4 * ACC_W;
  localparam int NUM_W        = 56;
  localparam int REM_W        = 58;
  localparam int QB_W         = 17;   // integer bit plus sixteen fraction bits
  localparam int Q_W          = 16;
  localparam int AREA_W       = 41;
  localparam int CNT_W        = 6;
  localparam int DIV_CNT_W    = 5;

  localparam logic [VIDX_W-1:0]    CLR_LAST    = VIDX_W'(VERTEX_COUNT - 1);
  localparam logic [CNT_W-1:0]     RD_LAST     = CNT_W'(3);
  localparam logic [CNT_W-1:0]     CROSS_LAST  = CNT_W'(6);
  localparam logic [CNT_W-1:0]     SQ_LAST     = CNT_W'(9);
  localparam logic [CNT_W-1:0]     SQRT_LAST   = CNT_W'(ROOT_W - 1);
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS   = DIV_CNT_W'(QB_W);

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_FACE  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RDPOS,
    S_CROSS,
    S_SQSUM,
    S_SQRT,
    S_CHECK,
    S_DIV_GO,
    S_DIV_WAIT,
    S_ACC_RD,
    S_ACC_WR,
    S_QRD,
    S_QCHK,
    S_OUT
  } state_t;

  typedef struct packed {
    logic             start;
    logic             neg;
    logic [NUM_W-1:0] mag;
    logic [NUM_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic signed [Q_W-1:0] q;
  } div_rsp_t;

endpackage

>>> hw/rtl/mfvn_div.sv
// Iterative restoring divider giving a rounded, saturated Q1.15 quotient.
module mfvn_div (
  input  logic               clk,
  input  logic               rst,
  input  mfvn_pkg::div_req_t req,
  output mfvn_pkg::div_rsp_t rsp
);

  logic [mfvn_pkg::REM_W-1:0]     rem;
  logic [mfvn_pkg::NUM_W-1:0]     den;
  logic [mfvn_pkg::QB_W-1:0]      quo;
  logic                           neg;
  logic                           sat;
  logic                           done;
  logic [mfvn_pkg::DIV_CNT_W-1:0] cnt;

  logic [mfvn_pkg::REM_W-1:0] den_x;
  logic [mfvn_pkg::REM_W-1:0] rem_sub;
  logic                       ge;
  logic [mfvn_pkg::QB_W:0]    rnd;
  logic [mfvn_pkg::QB_W-1:0]  mag_q;
  logic [mfvn_pkg::QB_W-1:0]  cap;
  logic [mfvn_pkg::QB_W-1:0]  cap_neg;

  localparam logic [mfvn_pkg::QB_W-1:0] QMAX = mfvn_pkg::QB_W'(32768);

  assign den_x   = mfvn_pkg::REM_W'(den);
  assign ge      = rem >= den_x;
  assign rem_sub = ge ? rem - den_x : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        cnt <= mfvn_pkg::DIV_STEPS;
      end else if (cnt != '0) begin
        cnt  <= cnt - 1'b1;
        done <= (cnt == mfvn_pkg::DIV_CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= mfvn_pkg::REM_W'(req.mag);
      den <= req.den;
      neg <= req.neg;
      quo <= '0;
      sat <= mfvn_pkg::REM_W'(req.mag) >= {1'b0, req.den, 1'b0};
    end else if (cnt != '0) begin
      quo <= {quo[mfvn_pkg::QB_W-2:0], ge};
      rem <= {rem_sub[mfvn_pkg::REM_W-2:0], 1'b0};
    end
  end

  // round half away from zero, then clamp to the Q1.15 range
  assign rnd     = {1'b0, quo} + 1'b1;
  assign mag_q   = rnd[mfvn_pkg::QB_W:1];
  assign cap     = (sat || mag_q > QMAX) ? QMAX : mag_q;
  assign cap_neg = ~cap + 1'b1;

  assign rsp.busy = (cnt != '0);
  assign rsp.done = done;
  assign rsp.q    = neg ? signed'(cap_neg[mfvn_pkg::Q_W-1:0])
                        : ((cap == QMAX) ? 16'sh7FFF : signed'(cap[mfvn_pkg::Q_W-1:0]));

endmodule

>>> hw/rtl/mesh_face_vertex_normals.sv
// Top level: area-weighted vertex normals with one shared multiplier and divider.
// Sequence: load writes a vertex position; a face reads its three corners, then runs 6 cross
// multiplications, 9 square partials, 44 square-root steps, 3 divisions and 3 accumulator
// updates; a query reads one accumulator entry and runs 3 divisions; clear zeroes every entry.
// One item in flight at a time.
// Reset (synchronous, rst high) starts a clearing pass over all 1024 accumulator entries.
module mesh_face_vertex_normals (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  output logic                     item_stall,
  input  logic [1:0]               command,
  input  logic [9:0]               vertex_index,
  input  logic signed [19:0]       pos_x,
  input  logic signed [19:0]       pos_y,
  input  logic signed [19:0]       pos_z,
  input  logic [9:0]               corner_a,
  input  logic [9:0]               corner_b,
  input  logic [9:0]               corner_c,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic signed [15:0]       normal_x,
  output logic signed [15:0]       normal_y,
  output logic signed [15:0]       normal_z,
  output logic [40:0]              face_area,
  output logic                     degenerate
);

  `include "mesh_face_vertex_normals_assert.svh"

  // ---- storage ----
  // Positions: x in [19:0], y in [39:20], z in [59:40].
  logic [mfvn_pkg::PWORD_W-1:0]   pos_mem [mfvn_pkg::VERTEX_COUNT];
  // Accumulators: sum x, sum y, sum z (signed), length sum (unsigned), low to high.
  logic [mfvn_pkg::ACCWORD_W-1:0] acc_mem [mfvn_pkg::VERTEX_COUNT];

  logic [mfvn_pkg::PWORD_W-1:0]   pos_rd;
  logic [mfvn_pkg::ACCWORD_W-1:0] acc_rd;
  logic [mfvn_pkg::VIDX_W-1:0]    pos_addr;
  logic [mfvn_pkg::VIDX_W-1:0]    acc_addr;
  logic                           acc_we;
  logic [mfvn_pkg::ACCWORD_W-1:0] acc_wdata;

  // ---- control ----
  mfvn_pkg::state_t            state, state_next;
  logic [mfvn_pkg::CNT_W-1:0]  cnt;
  logic [mfvn_pkg::VIDX_W-1:0] clr_cnt;
  logic [1:0]                  k;
  logic [1:0]                  didx;
  logic                        item_acc;
  logic                        out_load;
  logic                        is_face;

  // ---- payload ----
  logic [mfvn_pkg::VIDX_W-1:0]        vidx, cor_a, cor_b, cor_c;
  logic signed [mfvn_pkg::POS_W-1:0]  pa_x, pa_y, pa_z;
  logic signed [mfvn_pkg::D_W-1:0]    d1_x, d1_y, d1_z, d2_x, d2_y, d2_z;
  logic signed [mfvn_pkg::CROSS_W-1:0] c_x, c_y, c_z;
  logic signed [mfvn_pkg::PROD_W-1:0] cp;
  logic signed [mfvn_pkg::PROD_W-1:0] mul_p;
  logic signed [mfvn_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic [mfvn_pkg::SUMSQ_W-1:0]       ssq;
  logic [mfvn_pkg::ROOT_W-1:0]        sroot;
  logic [mfvn_pkg::ROOT_W+1:0]        srem;
  logic [mfvn_pkg::LEN_W-1:0]         len;
  logic signed [mfvn_pkg::NUM_W-1:0]  dnum_x, dnum_y, dnum_z;
  logic [mfvn_pkg::NUM_W-1:0]         dden;
  logic signed [mfvn_pkg::Q_W-1:0]    nq_x, nq_y, nq_z;
  logic [mfvn_pkg::AREA_W-1:0]        area;
  logic                               degen;

  mfvn_pkg::div_req_t div_req;
  mfvn_pkg::div_rsp_t div_rsp;

  // ---- combinational datapath helpers ----
  logic signed [mfvn_pkg::CROSS_W-1:0] sq_c;
  logic [mfvn_pkg::CROSS_W-1:0]        sq_mag;
  logic [1:0]                          sq_kind;
  logic [mfvn_pkg::SUMSQ_W-1:0]        sq_term;
  logic [mfvn_pkg::ROOT_W+3:0]         srem_p;
  logic [mfvn_pkg::ROOT_W+3:0]         strial;
  logic                                sq_ge;
  logic [mfvn_pkg::ROOT_W-1:0]         root_final;
  logic [mfvn_pkg::LEN_W-1:0]          len_w;
  logic signed [mfvn_pkg::NUM_W-1:0]   dsel;
  logic signed [mfvn_pkg::POS_W-1:0]   rp_x, rp_y, rp_z;
  logic [mfvn_pkg::VIDX_W-1:0]         cor_k;

  localparam logic [1:0] K_HH = 2'd0;
  localparam logic [1:0] K_HL = 2'd1;
  localparam logic [1:0] K_LL = 2'd2;

  // saturating add of a cross component onto a signed normal sum
  function automatic logic [mfvn_pkg::ACC_W-1:0] sat_sum(
    input logic [mfvn_pkg::ACC_W-1:0] a,
    input logic signed [mfvn_pkg::CROSS_W-1:0] b
  );
    logic [mfvn_pkg::ACC_W:0] s;
    s = {a[mfvn_pkg::ACC_W-1], a} + (mfvn_pkg::ACC_W+1)'(b);
    if (s[mfvn_pkg::ACC_W] != s[mfvn_pkg::ACC_W-1])
      return s[mfvn_pkg::ACC_W] ? {1'b1, {(mfvn_pkg::ACC_W-1){1'b0}}}
                                : {1'b0, {(mfvn_pkg::ACC_W-1){1'b1}}};
    return s[mfvn_pkg::ACC_W-1:0];
  endfunction

  function automatic logic [mfvn_pkg::ACC_W-1:0] sat_len(
    input logic [mfvn_pkg::ACC_W-1:0] a,
    input logic [mfvn_pkg::LEN_W-1:0] b
  );
    logic [mfvn_pkg::ACC_W:0] s;
    s = {1'b0, a} + (mfvn_pkg::ACC_W+1)'(b);
    return s[mfvn_pkg::ACC_W] ? '1 : s[mfvn_pkg::ACC_W-1:0];
  endfunction

  assign rp_x = signed'(pos_rd[mfvn_pkg::POS_W-1:0]);
  assign rp_y = signed'(pos_rd[2*mfvn_pkg::POS_W-1:mfvn_pkg::POS_W]);
  assign rp_z = signed'(pos_rd[3*mfvn_pkg::POS_W-1:2*mfvn_pkg::POS_W]);

  // corner select: by read step in the position fetch, by k in accumulation
  always_comb begin
    case ((state == mfvn_pkg::S_RDPOS) ? cnt[1:0] : k)
      2'd0:    cor_k = cor_a;
      2'd1:    cor_k = cor_b;
      default: cor_k = cor_c;
    endcase
  end

  // shared multiplier operands: cross pairs, then square partial products
  always_comb begin
    sq_c    = c_x;
    sq_kind = K_HH;
    case (cnt)
      6'd0:    begin sq_c = c_x; sq_kind = K_HH; end
      6'd1:    begin sq_c = c_x; sq_kind = K_HL; end
      6'd2:    begin sq_c = c_x; sq_kind = K_LL; end
      6'd3:    begin sq_c = c_y; sq_kind = K_HH; end
      6'd4:    begin sq_c = c_y; sq_kind = K_HL; end
      6'd5:    begin sq_c = c_y; sq_kind = K_LL; end
      6'd6:    begin sq_c = c_z; sq_kind = K_HH; end
      6'd7:    begin sq_c = c_z; sq_kind = K_HL; end
      default: begin sq_c = c_z; sq_kind = K_LL; end
    endcase
    sq_mag = sq_c[mfvn_pkg::CROSS_W-1] ? -sq_c : sq_c;

    mul_a = '0;
    mul_b = '0;
    if (state == mfvn_pkg::S_CROSS) begin
      case (cnt)
        6'd0:    begin mul_a = mfvn_pkg::MUL_W'(d1_y); mul_b = mfvn_pkg::MUL_W'(d2_z); end
        6'd1:    begin mul_a = mfvn_pkg::MUL_W'(d1_z); mul_b = mfvn_pkg::MUL_W'(d2_y); end
        6'd2:    begin mul_a = mfvn_pkg::MUL_W'(d1_z); mul_b = mfvn_pkg::MUL_W'(d2_x); end
        6'd3:    begin mul_a = mfvn_pkg::MUL_W'(d1_x); mul_b = mfvn_pkg::MUL_W'(d2_z); end
        6'd4:    begin mul_a = mfvn_pkg::MUL_W'(d1_x); mul_b = mfvn_pkg::MUL_W'(d2_y); end
        default: begin mul_a = mfvn_pkg::MUL_W'(d1_y); mul_b = mfvn_pkg::MUL_W'(d2_x); end
      endcase
    end else begin
      case (sq_kind)
        K_HH: begin
          mul_a = {1'b0, sq_mag[mfvn_pkg::CMAG_W-1:21]};
          mul_b = {1'b0, sq_mag[mfvn_pkg::CMAG_W-1:21]};
        end
        K_HL: begin
          mul_a = {1'b0, sq_mag[mfvn_pkg::CMAG_W-1:21]};
          mul_b = {2'b00, sq_mag[20:0]};
        end
        default: begin
          mul_a = {2'b00, sq_mag[20:0]};
          mul_b = {2'b00, sq_mag[20:0]};
        end
      endcase
    end
  end

  // placement of the product just registered (issued in the step before)
  always_comb begin
    case (cnt)
      6'd1, 6'd4, 6'd7: sq_term = mfvn_pkg::SUMSQ_W'(unsigned'(mul_p)) << 42;
      6'd2, 6'd5, 6'd8: sq_term = mfvn_pkg::SUMSQ_W'(unsigned'(mul_p)) << 22;
      default:          sq_term = mfvn_pkg::SUMSQ_W'(unsigned'(mul_p));
    endcase
  end

  // one digit-by-digit square-root step
  assign srem_p = {srem, ssq[mfvn_pkg::SUMSQ_W-1:mfvn_pkg::SUMSQ_W-2]};
  assign strial = (mfvn_pkg::ROOT_W+4)'({sroot, 2'b01});
  assign sq_ge  = srem_p >= strial;

  // the length clamps at 43 bits
  assign root_final = sroot;
  assign len_w = root_final[mfvn_pkg::ROOT_W-1] ? '1 : root_final[mfvn_pkg::LEN_W-1:0];

  always_comb begin
    case (didx)
      2'd0:    dsel = dnum_x;
      2'd1:    dsel = dnum_y;
      default: dsel = dnum_z;
    endcase
  end

  assign div_req.neg = dsel[mfvn_pkg::NUM_W-1];
  assign div_req.mag = dsel[mfvn_pkg::NUM_W-1] ? unsigned'(-dsel) : unsigned'(dsel);
  assign div_req.den = dden;

  assign acc_wdata = (state == mfvn_pkg::S_CLEAR) ? '0 :
    {sat_len(acc_rd[4*mfvn_pkg::ACC_W-1:3*mfvn_pkg::ACC_W], len),
     sat_sum(acc_rd[3*mfvn_pkg::ACC_W-1:2*mfvn_pkg::ACC_W], c_z),
     sat_sum(acc_rd[2*mfvn_pkg::ACC_W-1:mfvn_pkg::ACC_W], c_y),
     sat_sum(acc_rd[mfvn_pkg::ACC_W-1:0], c_x)};

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mfvn_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    item_stall    = 1'b1;
    div_req.start = 1'b0;
    out_load      = 1'b0;
    acc_we        = 1'b0;
    pos_addr      = cor_k;
    acc_addr      = cor_k;
    case (state)
      mfvn_pkg::S_CLEAR: begin
        acc_addr = clr_cnt;
        acc_we   = 1'b1;
        if (clr_cnt == mfvn_pkg::CLR_LAST) state_next = mfvn_pkg::S_IDLE;
      end
      mfvn_pkg::S_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          case (mfvn_pkg::cmd_t'(command))
            mfvn_pkg::CMD_FACE:  state_next = mfvn_pkg::S_RDPOS;
            mfvn_pkg::CMD_QUERY: state_next = mfvn_pkg::S_QRD;
            mfvn_pkg::CMD_CLEAR: state_next = mfvn_pkg::S_CLEAR;
            default:             state_next = mfvn_pkg::S_IDLE;
          endcase
        end
      end
      mfvn_pkg::S_RDPOS: begin
        if (cnt == mfvn_pkg::RD_LAST) state_next = mfvn_pkg::S_CROSS;
      end
      mfvn_pkg::S_CROSS: begin
        if (cnt == mfvn_pkg::CROSS_LAST) state_next = mfvn_pkg::S_SQSUM;
      end
      mfvn_pkg::S_SQSUM: begin
        if (cnt == mfvn_pkg::SQ_LAST) state_next = mfvn_pkg::S_SQRT;
      end
      mfvn_pkg::S_SQRT: begin
        if (cnt == mfvn_pkg::SQRT_LAST) state_next = mfvn_pkg::S_CHECK;
      end
      mfvn_pkg::S_CHECK: begin
        state_next = (len_w == '0) ? mfvn_pkg::S_OUT : mfvn_pkg::S_DIV_GO;
      end
      mfvn_pkg::S_DIV_GO: begin
        div_req.start = 1'b1;
        state_next    = mfvn_pkg::S_DIV_WAIT;
      end
      mfvn_pkg::S_DIV_WAIT: begin
        if (div_rsp.done) begin
          if (didx == 2'd2) begin
            state_next = is_face ? mfvn_pkg::S_ACC_RD : mfvn_pkg::S_OUT;
          end else begin
            state_next = mfvn_pkg::S_DIV_GO;
          end
        end
      end
      mfvn_pkg::S_ACC_RD: state_next = mfvn_pkg::S_ACC_WR;
      mfvn_pkg::S_ACC_WR: begin
        acc_we     = 1'b1;
        state_next = (k == 2'd2) ? mfvn_pkg::S_OUT : mfvn_pkg::S_ACC_RD;
      end
      mfvn_pkg::S_QRD: begin
        acc_addr   = vidx;
        state_next = mfvn_pkg::S_QCHK;
      end
      mfvn_pkg::S_QCHK: begin
        acc_addr   = vidx;
        state_next = (acc_rd[4*mfvn_pkg::ACC_W-1:3*mfvn_pkg::ACC_W] == '0) ?
                     mfvn_pkg::S_OUT : mfvn_pkg::S_DIV_GO;
      end
      mfvn_pkg::S_OUT: begin
        if (!result_valid || !result_stall) begin
          out_load   = 1'b1;
          state_next = mfvn_pkg::S_IDLE;
        end
      end
      default: state_next = mfvn_pkg::S_IDLE;
    endcase
  end

  assign item_acc = item_valid && !item_stall;

  // counters and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt          <= '0;
      clr_cnt      <= '0;
      k            <= '0;
      didx         <= '0;
      result_valid <= 1'b0;
    end else begin
      if (state != state_next) begin
        cnt <= '0;
      end else begin
        cnt <= cnt + 1'b1;
      end
      if (state == mfvn_pkg::S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end else begin
        clr_cnt <= '0;
      end
      if (state == mfvn_pkg::S_CHECK || state == mfvn_pkg::S_QCHK) begin
        didx <= '0;
      end else if (state == mfvn_pkg::S_DIV_WAIT && div_rsp.done) begin
        didx <= didx + 1'b1;
      end
      if (state == mfvn_pkg::S_DIV_WAIT) begin
        k <= '0;
      end else if (state == mfvn_pkg::S_ACC_WR) begin
        k <= k + 1'b1;
      end
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (item_acc && mfvn_pkg::cmd_t'(command) == mfvn_pkg::CMD_LOAD) begin
      pos_mem[vertex_index] <= {pos_z, pos_y, pos_x};
    end
    pos_rd <= pos_mem[pos_addr];
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[acc_addr] <= acc_wdata;
    end
    acc_rd <= acc_mem[acc_addr];
  end

  // datapath
  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;

    if (item_acc) begin
      vidx    <= vertex_index;
      cor_a   <= corner_a;
      cor_b   <= corner_b;
      cor_c   <= corner_c;
      is_face <= (mfvn_pkg::cmd_t'(command) == mfvn_pkg::CMD_FACE);
    end

    if (state == mfvn_pkg::S_RDPOS) begin
      case (cnt)
        6'd1: begin
          pa_x <= rp_x;
          pa_y <= rp_y;
          pa_z <= rp_z;
        end
        6'd2: begin
          d1_x <= mfvn_pkg::D_W'(rp_x) - mfvn_pkg::D_W'(pa_x);
          d1_y <= mfvn_pkg::D_W'(rp_y) - mfvn_pkg::D_W'(pa_y);
          d1_z <= mfvn_pkg::D_W'(rp_z) - mfvn_pkg::D_W'(pa_z);
        end
        6'd3: begin
          d2_x <= mfvn_pkg::D_W'(rp_x) - mfvn_pkg::D_W'(pa_x);
          d2_y <= mfvn_pkg::D_W'(rp_y) - mfvn_pkg::D_W'(pa_y);
          d2_z <= mfvn_pkg::D_W'(rp_z) - mfvn_pkg::D_W'(pa_z);
        end
        default: ;
      endcase
    end

    if (state == mfvn_pkg::S_CROSS) begin
      case (cnt)
        6'd1, 6'd3, 6'd5: cp <= mul_p;
        6'd2: c_x <= mfvn_pkg::CROSS_W'(cp - mul_p);
        6'd4: c_y <= mfvn_pkg::CROSS_W'(cp - mul_p);
        6'd6: c_z <= mfvn_pkg::CROSS_W'(cp - mul_p);
        default: ;
      endcase
      ssq <= '0;
    end

    if (state == mfvn_pkg::S_SQSUM) begin
      if (cnt != '0) ssq <= ssq + sq_term;
      sroot <= '0;
      srem  <= '0;
    end

    if (state == mfvn_pkg::S_SQRT) begin
      ssq <= ssq << 2;
      if (sq_ge) begin
        srem  <= (mfvn_pkg::ROOT_W+2)'(srem_p - strial);
        sroot <= {sroot[mfvn_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        srem  <= (mfvn_pkg::ROOT_W+2)'(srem_p);
        sroot <= {sroot[mfvn_pkg::ROOT_W-2:0], 1'b0};
      end
    end

    if (state == mfvn_pkg::S_CHECK) begin
      len    <= len_w;
      degen  <= (len_w == '0);
      area   <= len_w[mfvn_pkg::AREA_W:1];
      dnum_x <= mfvn_pkg::NUM_W'(c_x);
      dnum_y <= mfvn_pkg::NUM_W'(c_y);
      dnum_z <= mfvn_pkg::NUM_W'(c_z);
      dden   <= mfvn_pkg::NUM_W'(len_w);
      nq_x   <= '0;
      nq_y   <= '0;
      nq_z   <= '0;
    end

    if (state == mfvn_pkg::S_QCHK) begin
      degen  <= (acc_rd[4*mfvn_pkg::ACC_W-1:3*mfvn_pkg::ACC_W] == '0);
      area   <= '0;
      dnum_x <= signed'(acc_rd[mfvn_pkg::ACC_W-1:0]);
      dnum_y <= signed'(acc_rd[2*mfvn_pkg::ACC_W-1:mfvn_pkg::ACC_W]);
      dnum_z <= signed'(acc_rd[3*mfvn_pkg::ACC_W-1:2*mfvn_pkg::ACC_W]);
      dden   <= acc_rd[4*mfvn_pkg::ACC_W-1:3*mfvn_pkg::ACC_W];
      nq_x   <= '0;
      nq_y   <= '0;
      nq_z   <= '0;
    end

    if (state == mfvn_pkg::S_DIV_WAIT && div_rsp.done) begin
      case (didx)
        2'd0:    nq_x <= div_rsp.q;
        2'd1:    nq_y <= div_rsp.q;
        default: nq_z <= div_rsp.q;
      endcase
    end

    if (out_load) begin
      normal_x   <= nq_x;
      normal_y   <= nq_y;
      normal_z   <= nq_z;
      face_area  <= area;
      degenerate <= degen;
    end
  end

  mfvn_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // ---- checks ----
  `MFVN_ASSERT_SAME(a_degen_zero, clk, rst, result_valid && degenerate, normal_x == 16'sd0 && normal_y == 16'sd0 && normal_z == 16'sd0 && face_area == '0)
  `MFVN_ASSERT_SAME(a_div_idle, clk, rst, div_req.start, !div_rsp.busy)
  `MFVN_ASSERT_NEXT(a_clear_end, clk, rst, state == mfvn_pkg::S_CLEAR && clr_cnt == mfvn_pkg::CLR_LAST, state == mfvn_pkg::S_IDLE)
  `MFVN_ASSERT_SAME(a_new_result, clk, rst, result_valid && !$past(result_valid), $past(state) == mfvn_pkg::S_OUT)

endmodule
